### src/gpfd_pkg.sv
// Package for the protobuf field deframer: parser phases, status codes,
// wire types, action codes, the field-1 key and the field widths.
// No dependencies.
`default_nettype none
package gpfd_pkg;

	typedef enum logic [5:0] {
		PH_PREFIX  = 6'b000001,
		PH_KEY     = 6'b000010,
		PH_VARSKIP = 6'b000100,
		PH_LEN     = 6'b001000,
		PH_SKIP    = 6'b010000,
		PH_CAPTURE = 6'b100000
	} phase_t;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_COMPRESSED = 3'd1;
	localparam logic [2:0] ST_TOO_LONG   = 3'd2;
	localparam logic [2:0] ST_INVALID    = 3'd3;
	localparam logic [2:0] ST_OVERSIZE   = 3'd4;

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_FIX64  = 3'd1;
	localparam logic [2:0] WT_LEN    = 3'd2;
	localparam logic [2:0] WT_SGROUP = 3'd3;
	localparam logic [2:0] WT_EGROUP = 3'd4;
	localparam logic [2:0] WT_FIX32  = 3'd5;

	localparam logic       ACT_FEED = 1'b0;
	localparam logic       ACT_READ = 1'b1;

	localparam logic [31:0] KEY_FIELD1 = 32'h0000_000a;
	localparam int          MSG_W      = 23;
	localparam int          KEY_W      = 32;
	localparam int          FIELD_W    = 29;

endpackage
`default_nettype wire

### src/gpfd_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No dependencies.
`default_nettype none
module gpfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### src/grpc_protobuf_field_deframer_unit.sv
// gRPC length-prefixed protobuf field deframer, top level.
// Depends on gpfd_pkg and gpfd_ram (group stack and payload buffer).
//
// Channels: s_axis (tdata[0] action, tdata[8:1] data_byte) carries one
// action per transfer; m_axis returns one result per action; cfg writes
// max_message_size; the user must write it only while the block is idle,
// which the block does not enforce. Each action is evaluated combinationally
// from registered state; a feed's result enters the result stage in the cycle
// after its transfer. One action per cycle is sustained while results are
// taken: the group stack is a synchronous RAM whose top entry is held in a
// register (written on push; after a pop the RAM output is used as the top
// in the next cycle and captured into the register). Payload reads go to the
// buffer RAM, a read's result entry being patched with the registered RAM
// output in the next cycle; results pass through a two-entry stage.
// A result is held until taken; s_axis_tready drops only when the result
// stage is full and its head is not leaving, so a stalled receiver
// back-pressures the sender.
// Reset clears all control state; stores are undefined until written and
// need no clearing pass.
`default_nettype none
module grpc_protobuf_field_deframer_unit
	import gpfd_pkg::*;
#(
	parameter int BUFFER_DEPTH   = 16384,
	parameter int MAX_GROUP_NEST = 100
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [22:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	// [0] action, [8:1] data_byte
	input  wire logic [15:0] s_axis_tdata,
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] accepted, [3:1] status, [4] payload_ready, [19:5] payload_length,
	// [27:20] out_byte, [28] out_valid
	output      logic [31:0] m_axis_tdata,
	// out_last
	output      logic        m_axis_tlast
);

	localparam int AW  = $clog2(BUFFER_DEPTH);
	localparam int LW  = $clog2(BUFFER_DEPTH + 1);
	localparam int GW  = $clog2(MAX_GROUP_NEST + 1);
	localparam int GAW = (MAX_GROUP_NEST > 1) ? $clog2(MAX_GROUP_NEST) : 1;

	logic [MSG_W-1:0]   max_size_q;
	phase_t             phase_q;
	logic [2:0]         pcount_q;
	logic [MSG_W-1:0]   mlen_q, mrecv_q, skip_q;
	logic [63:0]        vval_q;
	logic [3:0]         vshift_q;
	logic [KEY_W-1:0]   key_q;
	logic [GW-1:0]      gdepth_q;
	logic [FIELD_W-1:0] gtop_q;
	logic               gtop_reload_q;
	logic [LW-1:0]      slen_q, rptr_q;
	logic [2:0]         err_q;
	logic               pend_q;

	// Result stage: two entries
	logic [1:0]  rcnt_q;
	logic [31:0] rdat_q [2];
	logic        rlast_q [2];
	logic        rrd_q   [2];
	logic        rd_pending_s1;

	logic        act, take, pop;
	logic [7:0]  b;
	logic [7:0]  buf_rdata;
	logic [FIELD_W-1:0] gram_rdata;

	assign cfg_ready = 1'b1;
	assign act  = s_axis_tdata[0];
	assign b    = s_axis_tdata[8:1];
	assign s_axis_tready = (rcnt_q != 2'd2) || pop;
	assign take = s_axis_tvalid && s_axis_tready;
	assign pop  = m_axis_tvalid && m_axis_tready;

	// next-state logic
	phase_t             n_phase;
	logic [2:0]         n_pcount, n_err;
	logic [MSG_W-1:0]   n_mlen, n_mrecv, n_skip;
	logic [63:0]        n_vval;
	logic [3:0]         n_vshift;
	logic [KEY_W-1:0]   n_key;
	logic [GW-1:0]      n_gdepth;
	logic [FIELD_W-1:0] n_gtop;
	logic               n_reload, g_we;
	logic [GAW-1:0]     g_waddr;
	logic [LW-1:0]      n_slen, n_rptr;
	logic               n_pend, acc, ov, ol, b_we;
	logic [AW-1:0]      b_waddr, b_raddr;
	logic [MSG_W-1:0]   left;
	logic [63:0]        vcur, pref;
	logic               vdone, vbad;
	logic [31:0]        plen;
	logic [KEY_W-1:0]   kv;
	logic [LW-1:0]      idx;
	logic [FIELD_W-1:0] top_now;

	always_comb begin
		n_phase = phase_q; n_pcount = pcount_q; n_err = err_q;
		n_mlen = mlen_q; n_mrecv = mrecv_q; n_skip = skip_q;
		n_vval = vval_q; n_vshift = vshift_q; n_key = key_q;
		n_gdepth = gdepth_q; n_reload = 1'b0;
		g_we = 1'b0; g_waddr = gdepth_q[GAW-1:0];
		n_slen = slen_q; n_rptr = rptr_q; n_pend = pend_q;
		acc = 1'b0; ov = 1'b0; ol = 1'b0; b_we = 1'b0;
		b_waddr = '0; b_raddr = rptr_q[AW-1:0];
		top_now = gtop_reload_q ? gram_rdata : gtop_q;
		n_gtop = top_now;
		left = mlen_q - mrecv_q - 1'b1;
		vbad = (vshift_q >= 4'd9) && (b > 8'd1);
		vcur = vval_q | ({57'd0, b[6:0]} << (7 * vshift_q));
		vdone = !b[7];
		pref = {vval_q[31:0], b};
		plen = pref[31:0];
		kv = vcur[KEY_W-1:0];
		idx = slen_q - skip_q[LW-1:0];
		if (take && act == ACT_FEED && err_q == ST_OK && !pend_q) begin
			acc = 1'b1;
			if (phase_q == PH_PREFIX) begin
				n_vval = {24'd0, pref[39:0]};
				n_pcount = pcount_q + 1'b1;
				if (pcount_q == 3'd4) begin
					if (pref[39:32] != 8'd0)
						n_err = ST_COMPRESSED;
					else if (plen > {9'd0, max_size_q})
						n_err = ST_TOO_LONG;
					else begin
						n_mlen = plen[MSG_W-1:0]; n_mrecv = '0; n_slen = '0;
						n_gdepth = '0; n_key = '0; n_vval = '0; n_vshift = '0;
						n_phase = PH_KEY;
						if (plen == 32'd0) begin
							n_phase = PH_PREFIX; n_pcount = '0; n_rptr = '0;
						end
					end
				end
			end else begin
				case (phase_q)
					PH_KEY, PH_VARSKIP, PH_LEN: begin
						if (vbad)
							n_err = ST_INVALID;
						else if (!vdone) begin
							n_vval = vcur; n_vshift = vshift_q + 1'b1;
						end else begin
							n_vval = '0; n_vshift = '0;
							if (phase_q == PH_VARSKIP)
								n_phase = PH_KEY;
							else if (phase_q == PH_LEN) begin
								if (vcur > {41'd0, left})
									n_err = ST_INVALID;
								else begin
									n_skip = vcur[MSG_W-1:0];
									if (key_q == KEY_FIELD1 && gdepth_q == '0) begin
										if ({41'd0, vcur[MSG_W-1:0]} > 64'(BUFFER_DEPTH))
											n_err = ST_OVERSIZE;
										else begin
											n_slen = vcur[LW-1:0];
											n_phase = (vcur == 0) ? PH_KEY : PH_CAPTURE;
										end
									end else
										n_phase = (vcur == 0) ? PH_KEY : PH_SKIP;
								end
								if (n_err != ST_OK) begin
									n_vval = vval_q; n_vshift = vshift_q;
								end
							end else if (vcur[63:32] != 0 || vcur[31:3] == 0)
								n_err = ST_INVALID;
							else begin
								n_key = kv;
								case (kv[2:0])
									WT_VARINT: n_phase = PH_VARSKIP;
									WT_FIX64: begin n_phase = PH_SKIP; n_skip = 23'd8; end
									WT_LEN: n_phase = PH_LEN;
									WT_SGROUP: begin
										if (gdepth_q >= GW'(MAX_GROUP_NEST))
											n_err = ST_INVALID;
										else begin
											g_we = 1'b1;
											n_gtop = kv[31:3];
											n_gdepth = gdepth_q + 1'b1;
										end
									end
									WT_EGROUP: begin
										if (gdepth_q == '0 || top_now != kv[31:3])
											n_err = ST_INVALID;
										else begin
											n_gdepth = gdepth_q - 1'b1;
											n_reload = (gdepth_q > GW'(1));
										end
									end
									WT_FIX32: begin n_phase = PH_SKIP; n_skip = 23'd4; end
									default: n_err = ST_INVALID;
								endcase
							end
						end
					end
					PH_SKIP: begin
						if (skip_q > left + 1'b1)
							n_err = ST_INVALID;
						else begin
							n_skip = skip_q - 1'b1;
							if (skip_q == 23'd1) begin
								n_phase = PH_KEY; n_vval = '0; n_vshift = '0;
							end
						end
					end
					PH_CAPTURE: begin
						b_we = 1'b1; b_waddr = idx[AW-1:0];
						n_skip = skip_q - 1'b1;
						if (skip_q == 23'd1) begin
							n_phase = PH_KEY; n_vval = '0; n_vshift = '0;
						end
					end
					default: n_err = ST_INVALID;
				endcase
				if (n_err == ST_OK) begin
					n_mrecv = mrecv_q + 1'b1;
					if (n_mrecv >= mlen_q) begin
						if (n_phase != PH_KEY || n_vshift != 0 || n_gdepth != 0)
							n_err = ST_INVALID;
						else begin
							n_phase = PH_PREFIX; n_pcount = '0; n_vval = '0;
							n_rptr = '0;
							if (n_slen != 0) n_pend = 1'b1;
						end
					end
				end
			end
		end else if (take && act == ACT_READ && pend_q && rptr_q < slen_q) begin
			ov = 1'b1;
			n_rptr = rptr_q + 1'b1;
			if (n_rptr >= slen_q) begin
				ol = 1'b1; n_pend = 1'b0; n_slen = '0; n_rptr = '0;
			end
		end
	end

	gpfd_ram #(.WIDTH(FIELD_W), .DEPTH(MAX_GROUP_NEST)) u_gstack (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(kv[31:3]),
		.re(n_reload), .raddr(GAW'(gdepth_q - GW'(2))), .rdata(gram_rdata)
	);

	gpfd_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_buf (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b),
		.re(ov), .raddr(b_raddr), .rdata(buf_rdata)
	);

	logic [31:0] res;
	logic [14:0] rem;
	assign rem = n_pend ? 15'(n_slen - n_rptr) : 15'd0;
	assign res = {3'd0, ov, 8'd0, rem, n_pend, n_err, acc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= 23'd4194304;
			phase_q <= PH_PREFIX; pcount_q <= '0; mlen_q <= '0; mrecv_q <= '0;
			skip_q <= '0; vval_q <= '0; vshift_q <= '0; key_q <= '0;
			gdepth_q <= '0; gtop_q <= '0; gtop_reload_q <= 1'b0;
			slen_q <= '0; rptr_q <= '0; err_q <= ST_OK; pend_q <= 1'b0;
		end else begin
			if (cfg_valid) max_size_q <= cfg_data;
			phase_q <= n_phase; pcount_q <= n_pcount; mlen_q <= n_mlen;
			mrecv_q <= n_mrecv; skip_q <= n_skip; vval_q <= n_vval;
			vshift_q <= n_vshift; key_q <= n_key; gdepth_q <= n_gdepth;
			gtop_q <= n_gtop; gtop_reload_q <= n_reload;
			slen_q <= n_slen; rptr_q <= n_rptr; err_q <= n_err; pend_q <= n_pend;
		end
	end

	// result queue; a read result picks up its byte from RAM after it is queued
	logic        wslot, pslot;
	logic [31:0] rdat_n  [2];
	logic        rlast_n [2];
	logic        rrd_n   [2];
	assign wslot = pop ? (rcnt_q == 2'd2) : (rcnt_q == 2'd1);
	assign pslot = (rcnt_q == 2'd2) && !pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0; rd_pending_s1 <= 1'b0;
		end else begin
			rcnt_q <= rcnt_q + 2'(take) - 2'(pop);
			rd_pending_s1 <= ov;
		end
	end

	always_comb begin
		rdat_n[0] = rdat_q[0]; rdat_n[1] = rdat_q[1];
		rlast_n[0] = rlast_q[0]; rlast_n[1] = rlast_q[1];
		rrd_n[0] = rrd_q[0]; rrd_n[1] = rrd_q[1];
		if (pop) begin
			rdat_n[0] = rdat_q[1]; rlast_n[0] = rlast_q[1]; rrd_n[0] = rrd_q[1];
		end
		// patch the newest entry with the byte now out of the RAM
		if (rd_pending_s1 && !(pop && rcnt_q == 2'd1))
			rdat_n[pslot][27:20] = buf_rdata;
		if (take) begin
			rdat_n[wslot] = res; rlast_n[wslot] = ol; rrd_n[wslot] = ov;
		end
	end

	always_ff @(posedge clk) begin
		rdat_q[0] <= rdat_n[0]; rdat_q[1] <= rdat_n[1];
		rlast_q[0] <= rlast_n[0]; rlast_q[1] <= rlast_n[1];
		rrd_q[0] <= rrd_n[0]; rrd_q[1] <= rrd_n[1];
	end

	// hold output until the late byte has landed
	assign m_axis_tvalid = (rcnt_q != 2'd0) && !(rd_pending_s1 && rcnt_q == 2'd1);
	assign m_axis_tdata  = rdat_q[0];
	assign m_axis_tlast  = rlast_q[0] && rrd_q[0];

endmodule
`default_nettype wire
